### rtl/grfa_pkg.sv
// Shared types and constants for the grid rectangle first-fit allocator.
package grfa_pkg;

    localparam int DIM_W    = 5;  // rectangle size and grid size fields
    localparam int CORNER_W = 4;  // corner fields on the ports
    localparam int CNT_W    = 6;  // row/column counters inside the block
    localparam int SUM_W    = 7;  // corner plus size, compared against limits

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = DIM_W;

    localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN_USE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_IN_USE = 1'd1;

    localparam logic OP_PLACE = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SEARCH,
        ST_UPDATE,
        ST_DONE
    } state_t;

endpackage

### rtl/grfa_if.sv
// Request and response channel interfaces of the allocator.
interface grfa_req_if;
    logic                              valid;
    logic                              ready;
    logic                              opcode;
    logic [grfa_pkg::DIM_W-1:0]        rect_width;
    logic [grfa_pkg::DIM_W-1:0]        rect_height;
    logic [grfa_pkg::CORNER_W-1:0]     corner_row;
    logic [grfa_pkg::CORNER_W-1:0]     corner_col;

    modport source (
        output valid, opcode, rect_width, rect_height, corner_row, corner_col,
        input  ready
    );
    modport sink (
        input  valid, opcode, rect_width, rect_height, corner_row, corner_col,
        output ready
    );
endinterface

interface grfa_rsp_if;
    logic                              valid;
    logic                              ready;
    logic                              success;
    logic [grfa_pkg::CORNER_W-1:0]     placed_row;
    logic [grfa_pkg::CORNER_W-1:0]     placed_col;

    modport source (
        output valid, success, placed_row, placed_col,
        input  ready
    );
    modport sink (
        input  valid, success, placed_row, placed_col,
        output ready
    );
endinterface

### rtl/grid_rectangle_first_fit_allocator.sv
// Top level: first-fit 2D rectangle allocator over a row-wide occupancy memory.
//
//   channel   dir   handshake           payload
//   req       in    valid/ready         opcode, rect_width, rect_height,
//                                       corner_row, corner_col
//   rsp       out   valid/ready         success, placed_row, placed_col
//   cfg       in    cfg_we (no stall)   cfg_index, cfg_data
//
// One item at a time. The occupancy memory has one read port and one row per
// cycle is read, so the row sweep sets how long an item takes:
//   free: one sweep over its rows; place at the proposed corner: a check sweep,
//   then an update sweep; place by search: the check, a column-major search, then the update.
// Reset clears the occupancy through per-row valid bits; no clearing pass.
// A finished result waits in the output register; the next request is taken
// while it waits, and the block stalls only if a second result is ready first.
module grid_rectangle_first_fit_allocator #(
    parameter int MAX_ROWS = 16,
    parameter int MAX_COLS = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [grfa_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [grfa_pkg::CFG_DATA_W-1:0]        cfg_data,
    grfa_req_if.sink                               req,
    grfa_rsp_if.source                             rsp
);

    localparam int AW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CNT_W = grfa_pkg::CNT_W;
    localparam int SUM_W = grfa_pkg::SUM_W;
    localparam int DIM_W = grfa_pkg::DIM_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [DIM_W-1:0] rows_reg;
    logic [DIM_W-1:0] cols_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= DIM_W'(16);
            cols_reg <= DIM_W'(16);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                grfa_pkg::REG_ROWS_IN_USE: rows_reg <= cfg_data;
                grfa_pkg::REG_COLS_IN_USE: cols_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // grid size clamped to the array
    logic [SUM_W-1:0] eff_rows;
    logic [SUM_W-1:0] eff_cols;

    assign eff_rows = (SUM_W'(rows_reg) > SUM_W'(MAX_ROWS)) ? SUM_W'(MAX_ROWS)
                                                             : SUM_W'(rows_reg);
    assign eff_cols = (SUM_W'(cols_reg) > SUM_W'(MAX_COLS)) ? SUM_W'(MAX_COLS)
                                                             : SUM_W'(cols_reg);

    // ------------------------------------------------------------------
    // Occupancy memory: one row per word, bit c set when column c is taken.
    // Rows never written since reset read as free through row_vld_reg.
    // ------------------------------------------------------------------
    logic [MAX_COLS-1:0] occ_mem [MAX_ROWS];
    logic [MAX_ROWS-1:0] row_vld_reg;
    logic [MAX_COLS-1:0] rd_q_reg;
    logic                rd_vld_reg;
    logic [MAX_COLS-1:0] rd_word;
    logic [AW-1:0]       rd_addr;
    logic [AW-1:0]       wr_addr;
    logic [MAX_COLS-1:0] wr_data;
    logic                mem_we;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            occ_mem[wr_addr] <= wr_data;
        end
        rd_q_reg <= occ_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_vld_reg <= '0;
            rd_vld_reg  <= 1'b0;
        end
        else
        begin
            if (mem_we)
            begin
                row_vld_reg[wr_addr] <= 1'b1;
            end
            rd_vld_reg <= row_vld_reg[rd_addr];
        end
    end

    assign rd_word = rd_vld_reg ? rd_q_reg : '0;

    // ------------------------------------------------------------------
    // Control and working registers
    // ------------------------------------------------------------------
    grfa_pkg::state_t state_reg, state_next;

    logic             op_reg,    op_next;
    logic [DIM_W-1:0] w_reg,     w_next;
    logic [DIM_W-1:0] h_reg,     h_next;
    logic [CNT_W-1:0] crow_reg,  crow_next;   // chosen / requested corner
    logic [CNT_W-1:0] ccol_reg,  ccol_next;
    logic [CNT_W-1:0] iss_row_reg, iss_row_next;  // row being read this cycle
    logic [CNT_W-1:0] iss_col_reg, iss_col_next;
    logic             p_vld_reg, p_vld_next;      // read data returns now
    logic [CNT_W-1:0] p_row_reg, p_row_next;
    logic [CNT_W-1:0] p_col_reg, p_col_next;
    logic [DIM_W-1:0] run_reg,   run_next;        // free rows in a row, this column
    logic             ok_reg,    ok_next;

    logic                       rsp_vld_reg, rsp_vld_next;
    logic                       rsp_ok_reg,  rsp_ok_next;
    logic [grfa_pkg::CORNER_W-1:0] rsp_row_reg, rsp_row_next;
    logic [grfa_pkg::CORNER_W-1:0] rsp_col_reg, rsp_col_next;

    // column mask of the rectangle at the column being checked
    logic [CNT_W-1:0]    mask_col;
    logic [MAX_COLS-1:0] col_mask;
    logic                row_free;

    assign mask_col = (state_reg == grfa_pkg::ST_SEARCH) ? p_col_reg : ccol_reg;

    always_comb
    begin
        for (int i = 0; i < MAX_COLS; i++)
        begin
            col_mask[i] = (SUM_W'(i) >= SUM_W'(mask_col)) &&
                          (SUM_W'(i) < SUM_W'(mask_col) + SUM_W'(w_reg));
        end
    end

    assign row_free = ((rd_word & col_mask) == '0);

    // common sums
    logic [SUM_W-1:0] corner_end;   // crow + h
    logic [SUM_W-1:0] upd_end;      // last row + 1 touched by the update
    logic [SUM_W-1:0] p_row_inc;
    logic             corner_in_grid;
    logic             dims_fit;

    assign corner_end     = SUM_W'(crow_reg) + SUM_W'(h_reg);
    assign upd_end        = (corner_end > SUM_W'(MAX_ROWS)) ? SUM_W'(MAX_ROWS) : corner_end;
    assign p_row_inc      = SUM_W'(p_row_reg) + SUM_W'(1);
    assign corner_in_grid = (corner_end <= eff_rows) &&
                            (SUM_W'(ccol_reg) + SUM_W'(w_reg) <= eff_cols);
    assign dims_fit       = (SUM_W'(w_reg) <= eff_cols) && (SUM_W'(h_reg) <= eff_rows);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= grfa_pkg::ST_IDLE;
            p_vld_reg   <= 1'b0;
            ok_reg      <= 1'b0;
            rsp_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            p_vld_reg   <= p_vld_next;
            ok_reg      <= ok_next;
            rsp_vld_reg <= rsp_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        w_reg       <= w_next;
        h_reg       <= h_next;
        crow_reg    <= crow_next;
        ccol_reg    <= ccol_next;
        iss_row_reg <= iss_row_next;
        iss_col_reg <= iss_col_next;
        p_row_reg   <= p_row_next;
        p_col_reg   <= p_col_next;
        run_reg     <= run_next;
        rsp_ok_reg  <= rsp_ok_next;
        rsp_row_reg <= rsp_row_next;
        rsp_col_reg <= rsp_col_next;
    end

    // ------------------------------------------------------------------
    // Next state and datapath
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        w_next       = w_reg;
        h_next       = h_reg;
        crow_next    = crow_reg;
        ccol_next    = ccol_reg;
        iss_row_next = iss_row_reg;
        iss_col_next = iss_col_reg;
        p_vld_next   = 1'b0;
        p_row_next   = p_row_reg;
        p_col_next   = p_col_reg;
        run_next     = run_reg;
        ok_next      = ok_reg;

        rsp_vld_next = rsp_vld_reg && !rsp.ready;
        rsp_ok_next  = rsp_ok_reg;
        rsp_row_next = rsp_row_reg;
        rsp_col_next = rsp_col_reg;

        mem_we  = 1'b0;
        rd_addr = iss_row_reg[AW-1:0];
        wr_addr = p_row_reg[AW-1:0];
        wr_data = (op_reg == grfa_pkg::OP_FREE) ? (rd_word & ~col_mask)
                                                : (rd_word | col_mask);

        req.ready = (state_reg == grfa_pkg::ST_IDLE);

        case (state_reg)
            grfa_pkg::ST_IDLE:
            begin
                if (req.valid)
                begin
                    op_next      = req.opcode;
                    w_next       = req.rect_width;
                    h_next       = req.rect_height;
                    crow_next    = CNT_W'(req.corner_row);
                    ccol_next    = CNT_W'(req.corner_col);
                    iss_row_next = CNT_W'(req.corner_row);
                    run_next     = '0;
                    ok_next      = 1'b1;
                    if (req.opcode == grfa_pkg::OP_FREE)
                    begin
                        // nothing to clear when the height is zero or the rows lie past the array
                        if (req.rect_height == '0 ||
                            SUM_W'(req.corner_row) >= SUM_W'(MAX_ROWS))
                        begin
                            state_next = grfa_pkg::ST_DONE;
                        end
                        else
                        begin
                            state_next = grfa_pkg::ST_UPDATE;
                        end
                    end
                    else if (req.rect_width == '0 || req.rect_height == '0)
                    begin
                        // empty rectangle fits at the proposed corner
                        state_next = grfa_pkg::ST_DONE;
                    end
                    else
                    begin
                        state_next = grfa_pkg::ST_CHECK;
                    end
                end
            end

            grfa_pkg::ST_CHECK:
            begin
                if (SUM_W'(iss_row_reg) < corner_end)
                begin
                    p_vld_next   = 1'b1;
                    p_row_next   = iss_row_reg;
                    iss_row_next = iss_row_reg + CNT_W'(1);
                end

                if (!corner_in_grid || (p_vld_reg && !row_free))
                begin
                    // proposed corner rejected: search column-major, or fail if it cannot fit
                    p_vld_next   = 1'b0;
                    iss_row_next = '0;
                    iss_col_next = '0;
                    run_next     = '0;
                    if (dims_fit)
                    begin
                        state_next = grfa_pkg::ST_SEARCH;
                    end
                    else
                    begin
                        ok_next    = 1'b0;
                        state_next = grfa_pkg::ST_DONE;
                    end
                end
                else if (p_vld_reg && p_row_inc == corner_end)
                begin
                    p_vld_next   = 1'b0;
                    iss_row_next = crow_reg;
                    state_next   = grfa_pkg::ST_UPDATE;
                end
            end

            grfa_pkg::ST_SEARCH:
            begin
                // read rows down each column; the mask follows the column
                if (SUM_W'(iss_col_reg) + SUM_W'(w_reg) <= eff_cols)
                begin
                    p_vld_next = 1'b1;
                    p_row_next = iss_row_reg;
                    p_col_next = iss_col_reg;
                    if (SUM_W'(iss_row_reg) + SUM_W'(1) == eff_rows)
                    begin
                        iss_row_next = '0;
                        iss_col_next = iss_col_reg + CNT_W'(1);
                    end
                    else
                    begin
                        iss_row_next = iss_row_reg + CNT_W'(1);
                    end
                end

                if (p_vld_reg)
                begin
                    if (row_free && (run_reg + DIM_W'(1) == h_reg))
                    begin
                        // first fitting corner: top row is h-1 rows above
                        crow_next    = CNT_W'(p_row_inc - SUM_W'(h_reg));
                        ccol_next    = p_col_reg;
                        iss_row_next = CNT_W'(p_row_inc - SUM_W'(h_reg));
                        p_vld_next   = 1'b0;
                        state_next   = grfa_pkg::ST_UPDATE;
                    end
                    else
                    begin
                        if (!row_free || p_row_inc == eff_rows)
                        begin
                            run_next = '0;
                        end
                        else
                        begin
                            run_next = run_reg + DIM_W'(1);
                        end
                        if (p_row_inc == eff_rows &&
                            SUM_W'(p_col_reg) + SUM_W'(1) + SUM_W'(w_reg) > eff_cols)
                        begin
                            p_vld_next = 1'b0;
                            ok_next    = 1'b0;
                            state_next = grfa_pkg::ST_DONE;
                        end
                    end
                end
            end

            grfa_pkg::ST_UPDATE:
            begin
                // read row k while row k-1 is written back
                if (SUM_W'(iss_row_reg) < upd_end)
                begin
                    p_vld_next   = 1'b1;
                    p_row_next   = iss_row_reg;
                    iss_row_next = iss_row_reg + CNT_W'(1);
                end
                if (p_vld_reg)
                begin
                    mem_we = 1'b1;
                    if (p_row_inc == upd_end)
                    begin
                        p_vld_next = 1'b0;
                        state_next = grfa_pkg::ST_DONE;
                    end
                end
            end

            grfa_pkg::ST_DONE:
            begin
                if (!rsp_vld_reg || rsp.ready)
                begin
                    rsp_vld_next = 1'b1;
                    rsp_ok_next  = ok_reg;
                    rsp_row_next = ok_reg ? crow_reg[grfa_pkg::CORNER_W-1:0] : '0;
                    rsp_col_next = ok_reg ? ccol_reg[grfa_pkg::CORNER_W-1:0] : '0;
                    state_next   = grfa_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = grfa_pkg::ST_IDLE;
            end
        endcase
    end

    assign rsp.valid      = rsp_vld_reg;
    assign rsp.success    = rsp_ok_reg;
    assign rsp.placed_row = rsp_row_reg;
    assign rsp.placed_col = rsp_col_reg;

`ifndef SYNTH
    // write-back stays inside the array
    a_wr_in_array: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (SUM_W'(p_row_reg) < SUM_W'(MAX_ROWS)))
        else $error("occupancy write beyond the array");

    // a failed placement reports a zero corner
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.success) |-> (rsp.placed_row == '0 && rsp.placed_col == '0))
        else $error("failed result with nonzero corner");

    // the free-row run never reaches the height without being taken
    a_run_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == grfa_pkg::ST_SEARCH) |-> (run_reg < h_reg))
        else $error("search run length overflow");

    // a finished item reaches the output register next cycle
    a_done_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == grfa_pkg::ST_DONE && (!rsp_vld_reg || rsp.ready))
        |=> (rsp.valid && state_reg == grfa_pkg::ST_IDLE))
        else $error("result not loaded");

    // a new request is never taken while a read-modify-write is in flight
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |-> !p_vld_reg)
        else $error("request accepted with a row read pending");
`endif

endmodule

### dv/grid_rectangle_first_fit_allocator_checker.sv
// Checker for the grid allocator: tracks occupancy, predicts each result, compares transfers.
module grid_rectangle_first_fit_allocator_checker #(
    parameter int MAX_ROWS = 16,
    parameter int MAX_COLS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [grfa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [grfa_pkg::CFG_DATA_W-1:0] cfg_data,
    grfa_req_if                             req,
    grfa_rsp_if                             rsp,
    output int                              fail_count,
    output int                              pending
);
    import grfa_pkg::*;

    typedef struct packed {
        logic                success;
        logic [CORNER_W-1:0] row;
        logic [CORNER_W-1:0] col;
    } alloc_result_t;

    logic [MAX_COLS-1:0] occ_map [MAX_ROWS];
    logic [DIM_W-1:0]    grid_rows;
    logic [DIM_W-1:0]    grid_cols;
    alloc_result_t       expected_q [$];
    int                  n_fail = 0;
    int                  n_pending = 0;
    int                  n_results = 0;

    assign fail_count = n_fail;
    assign pending    = n_pending;

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch at result %0d: %s got %0d want %0d", n_results, what, got, want);
        n_fail++;
    endtask

    function automatic logic [MAX_COLS-1:0] span_bits(int col, int w);
        logic [MAX_COLS-1:0] bits;
        int c;
        bits = '0;
        for (c = col; c < col + w && c < MAX_COLS; c++)
            bits[c] = 1'b1;
        return bits;
    endfunction

    function automatic bit rect_fits(int w, int h, int row, int col, int er, int ec);
        logic [MAX_COLS-1:0] bits;
        int r;
        if (w == 0 || h == 0)
            return 1'b1;
        if (row + h > er || col + w > ec)
            return 1'b0;
        bits = span_bits(col, w);
        for (r = row; r < row + h; r++)
            if ((occ_map[r] & bits) != '0)
                return 1'b0;
        return 1'b1;
    endfunction

    // Applies one request to the occupancy copy and returns the expected result.
    function automatic alloc_result_t predict_alloc(logic op, int w, int h, int row, int col);
        alloc_result_t       res;
        logic [MAX_COLS-1:0] bits;
        int                  er, ec, r, c, r0, c0;
        bit                  found;
        er = (grid_rows > MAX_ROWS) ? MAX_ROWS : int'(grid_rows);
        ec = (grid_cols > MAX_COLS) ? MAX_COLS : int'(grid_cols);
        r0 = row;
        c0 = col;
        if (op == OP_FREE)
        begin
            bits = span_bits(c0, w);
            for (r = r0; r < r0 + h && r < MAX_ROWS; r++)
                occ_map[r] &= ~bits;
            res.success = 1'b1;
            res.row     = CORNER_W'(row);
            res.col     = CORNER_W'(col);
            return res;
        end
        found = rect_fits(w, h, r0, c0, er, ec);
        // column-major first fit
        if (!found && w <= ec && h <= er)
        begin
            for (c = 0; !found && c + w <= ec; c++)
                for (r = 0; r + h <= er; r++)
                    if (!found && rect_fits(w, h, r, c, er, ec))
                    begin
                        r0    = r;
                        c0    = c;
                        found = 1'b1;
                    end
        end
        if (!found)
            return '0;
        if (w != 0 && h != 0)
        begin
            bits = span_bits(c0, w);
            for (r = r0; r < r0 + h && r < MAX_ROWS; r++)
                occ_map[r] |= bits;
        end
        res.success = 1'b1;
        res.row     = CORNER_W'(r0);
        res.col     = CORNER_W'(c0);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        alloc_result_t want;
        if (!rst_n)
        begin
            for (int r = 0; r < MAX_ROWS; r++)
                occ_map[r] = '0;
            grid_rows = DIM_W'(16);
            grid_cols = DIM_W'(16);
            expected_q.delete();
            n_pending = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_ROWS_IN_USE)
                    grid_rows = cfg_data;
                else if (cfg_index == REG_COLS_IN_USE)
                    grid_cols = cfg_data;
            end
            if (rsp.valid && rsp.ready)
            begin
                n_results++;
                if (expected_q.size() == 0)
                    report_mismatch("result with nothing pending, success",
                                    int'(rsp.success), -1);
                else
                begin
                    want = expected_q.pop_front();
                    if (rsp.success !== want.success)
                        report_mismatch("success", int'(rsp.success), int'(want.success));
                    if (rsp.placed_row !== want.row)
                        report_mismatch("placed_row", int'(rsp.placed_row), int'(want.row));
                    if (rsp.placed_col !== want.col)
                        report_mismatch("placed_col", int'(rsp.placed_col), int'(want.col));
                end
            end
            if (req.valid && req.ready)
                expected_q.push_back(predict_alloc(req.opcode, int'(req.rect_width),
                                                   int'(req.rect_height),
                                                   int'(req.corner_row),
                                                   int'(req.corner_col)));
            n_pending = expected_q.size();
        end
    end

endmodule

### dv/grid_rectangle_first_fit_allocator_tb.sv
// Testbench top for the grid allocator: clock, reset, stimulus, ready control and verdict.
module grid_rectangle_first_fit_allocator_tb;
    import grfa_pkg::*;

    // The limit stays well above the length of a correct run.
    localparam int LIMIT        = 1_500_000;
    localparam int SETTLE_CYCLES = 400;   // above the worst single-item latency
    localparam int PHASES       = 12;
    localparam int PHASE_ITEMS  = 75;
    localparam int HOLD_CYCLES  = 600;    // long receiver hold-off

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    grfa_req_if req_ch ();
    grfa_rsp_if rsp_ch ();

    int fail_count;
    int pending;
    int cycle_count = 0;
    int hold_len    = 0;   // handed to the receiver, consumed there
    bit gaps_on     = 1'b1;

    // grid size as last written; only used to shape rectangle sizes and corners
    logic [DIM_W-1:0] shape_rows = DIM_W'(16);
    logic [DIM_W-1:0] shape_cols = DIM_W'(16);

    // Grid settings for the first ten phases: extremes (0, 1, 16, clamped 31), thin strips,
    // shrink after a full grid and growth back onto stale occupancy.
    logic [DIM_W-1:0] row_set [10] = '{16, 1, 4, 31, 16, 0, 1, 3, 16, 9};
    logic [DIM_W-1:0] col_set [10] = '{16, 1, 7, 31, 1, 5, 16, 12, 16, 13};

    grid_rectangle_first_fit_allocator #(
        .MAX_ROWS(16),
        .MAX_COLS(16)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .req      (req_ch),
        .rsp      (rsp_ch)
    );

    grid_rectangle_first_fit_allocator_checker #(
        .MAX_ROWS(16),
        .MAX_COLS(16)
    ) u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .fail_count(fail_count),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard stop if the block hangs.
    initial
    begin
        while (cycle_count < LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // Response side: per result a random wait with ready low, unless
    // idling is off; a requested hold-off replaces the draw once.
    initial
    begin
        int gap;
        rsp_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_len > 0)
            begin
                gap      = hold_len;
                hold_len = 0;
            end
            else
                gap = gaps_on ? int'($urandom_range(0, 8)) : 0;
            if (gap > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge clk);
            while (!rsp_ch.valid)
                @(posedge clk);
        end
    end

    // One request transfer. valid is only dropped when a gap follows, so a
    // back-to-back item never sees valid lowered and raised in one step.
    task automatic send_req(logic op, logic [DIM_W-1:0] w, logic [DIM_W-1:0] h,
                            logic [CORNER_W-1:0] r, logic [CORNER_W-1:0] c);
        int gap;
        gap = gaps_on ? int'($urandom_range(0, 8)) : 0;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.opcode      <= op;
        req_ch.rect_width  <= w;
        req_ch.rect_height <= h;
        req_ch.corner_row  <= r;
        req_ch.corner_col  <= c;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    // Stop offering and wait for every outstanding result. Every request yields
    // a result, so the block is idle once the count reaches zero. The count is
    // read on the falling edge, away from the checker's updates.
    task automatic wait_results();
        req_ch.valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    // Both registers are written back to back, so cfg_we stays high across.
    task automatic set_grid(logic [DIM_W-1:0] rows, logic [DIM_W-1:0] cols);
        cfg_we    <= 1'b1;
        cfg_index <= REG_ROWS_IN_USE;
        cfg_data  <= rows;
        @(posedge clk);
        cfg_index <= REG_COLS_IN_USE;
        cfg_data  <= cols;
        @(posedge clk);
        cfg_we     <= 1'b0;
        shape_rows = rows;
        shape_cols = cols;
    endtask

    function automatic int dim_limit(logic [DIM_W-1:0] v);
        if (v == 0)
            return 1;
        return (v > 16) ? 16 : int'(v);
    endfunction

    // Mostly small sizes so the grid fills and the search works hard; a few
    // zero, full-grid and oversized ones.
    function automatic logic [DIM_W-1:0] pick_dim(int lim);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 3)
            return '0;
        if (roll < 6)
            return DIM_W'($urandom_range(17, 31));
        if (roll < 12)
            return DIM_W'(lim);
        return DIM_W'($urandom_range(1, (lim > 3) ? lim / 3 + 1 : lim));
    endfunction

    task automatic random_item();
        int                  lr, lc, roll;
        logic [DIM_W-1:0]    w, h;
        logic [CORNER_W-1:0] r, c;
        lr   = dim_limit(shape_rows);
        lc   = dim_limit(shape_cols);
        w    = pick_dim(lc);
        h    = pick_dim(lr);
        // corners mostly inside the grid in use, sometimes anywhere
        r    = CORNER_W'(($urandom_range(0, 99) < 80) ? $urandom_range(0, lr - 1)
                                                      : $urandom_range(0, 15));
        c    = CORNER_W'(($urandom_range(0, 99) < 80) ? $urandom_range(0, lc - 1)
                                                      : $urandom_range(0, 15));
        roll = $urandom_range(0, 99);
        if (roll < 3)
            send_req(OP_FREE, DIM_W'(16), DIM_W'(16), '0, '0);   // wipe everything
        else if (roll < 30)
            send_req(OP_FREE, w, h, r, c);
        else
            send_req(OP_PLACE, w, h, r, c);
    endtask

    initial
    begin
        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_index          <= REG_ROWS_IN_USE;
        cfg_data           <= '0;
        req_ch.valid       <= 1'b0;
        req_ch.opcode      <= OP_PLACE;
        req_ch.rect_width  <= '0;
        req_ch.rect_height <= '0;
        req_ch.corner_row  <= '0;
        req_ch.corner_col  <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part on the reset grid size (16 x 16).
        send_req(OP_PLACE, 5'd16, 5'd16, 4'd0,  4'd0);   // whole grid fits exactly
        send_req(OP_PLACE, 5'd1,  5'd1,  4'd15, 4'd15);  // grid full: fails
        send_req(OP_FREE,  5'd16, 5'd16, 4'd0,  4'd0);
        send_req(OP_PLACE, 5'd1,  5'd1,  4'd15, 4'd15);  // last cell at proposed corner
        send_req(OP_PLACE, 5'd17, 5'd1,  4'd0,  4'd0);   // wider than grid
        send_req(OP_PLACE, 5'd1,  5'd17, 4'd0,  4'd0);   // taller than grid
        send_req(OP_PLACE, 5'd0,  5'd3,  4'd5,  4'd9);   // zero width
        send_req(OP_PLACE, 5'd3,  5'd0,  4'd15, 4'd15);  // zero height
        send_req(OP_PLACE, 5'd31, 5'd31, 4'd15, 4'd15);  // field maximum
        send_req(OP_PLACE, 5'd2,  5'd2,  4'd15, 4'd15);  // off grid: search
        send_req(OP_PLACE, 5'd2,  5'd2,  4'd0,  4'd0);   // occupied: search down column
        send_req(OP_FREE,  5'd0,  5'd5,  4'd3,  4'd3);   // empty free echoes corner
        send_req(OP_FREE,  5'd31, 5'd31, 4'd15, 4'd15);  // free past the array edge
        send_req(OP_PLACE, 5'd16, 5'd1,  4'd0,  4'd5);   // full-width row
        send_req(OP_PLACE, 5'd1,  5'd16, 4'd3,  4'd0);   // full-height column: fails
        send_req(OP_FREE,  5'd16, 5'd16, 4'd0,  4'd0);
        send_req(OP_PLACE, 5'd4,  5'd3,  4'd13, 4'd12);
        send_req(OP_PLACE, 5'd15, 5'd16, 4'd0,  4'd1);
        send_req(OP_FREE,  5'd16, 5'd16, 4'd0,  4'd0);
        send_req(OP_PLACE, 5'd16, 5'd16, 4'd0,  4'd0);
        send_req(OP_FREE,  5'd5,  5'd5,  4'd15, 4'd15);  // only the corner cell is inside
        send_req(OP_PLACE, 5'd1,  5'd1,  4'd0,  4'd0);   // longest search, last corner
        wait_results();

        // Random phases, each on its own grid size. Every third phase runs
        // without idling on either side.
        for (int p = 0; p < PHASES; p++)
        begin
            if (p < 10)
                set_grid(row_set[p], col_set[p]);
            else
                set_grid(DIM_W'($urandom_range(1, 16)), DIM_W'($urandom_range(1, 16)));
            gaps_on = (p % 3 != 2);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                // receiver stalls for a long stretch while requests keep coming
                if (p == 2 && i == 20)
                    hold_len = HOLD_CYCLES;
                // sender stops until the block has drained
                if (p == 6 && i == 40)
                    wait_results();
                random_item();
            end
            wait_results();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
